// ----- rtl/core/aftf_pkg.sv -----
// ----------------------------------------------------------------------------
// Transmit frame framer package
// Shared types and constants for the transmit-request frame serializer.
// ----------------------------------------------------------------------------
package aftf_pkg;

  // Item kinds on the input channel
  typedef enum logic [0:0] {
    OpHeader  = 1'b0,
    OpPayload = 1'b1
  } op_e;

  // Configuration register map
  localparam int unsigned CfgIdxW        = 8;
  localparam logic [CfgIdxW-1:0] CfgFrameStart = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgTxApiId    = 8'd1;

  // Register reset values
  localparam logic [7:0] FrameStartRst = 8'd126;
  localparam logic [7:0] TxApiIdRst    = 8'd16;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned Addr64W = 64;
  localparam int unsigned Addr16W = 16;
  localparam int unsigned PlenW  = 9;
  localparam int unsigned FlenW  = 16;

  // Frame layout: start, length (2), API id, frame id, addr64 (8), addr16 (2),
  // radius, options -> 17 header bytes; summing starts at the API id.
  localparam int unsigned HdrBytes    = 17;
  localparam int unsigned IdxW        = 5;
  localparam logic [IdxW-1:0] SumStartIdx = 5'd3;
  localparam logic [IdxW-1:0] LastHdrIdx  = 5'd16;
  localparam logic [IdxW-1:0] CsumHdrIdx  = 5'd17;
  localparam logic [FlenW-1:0] FixedBodyLen = 16'd14;
  localparam logic [ByteW-1:0] CsumBase   = 8'hFF;

endpackage

// ----- rtl/core/aftf_if.sv -----
// ----------------------------------------------------------------------------
// Transmit frame framer channels
// Valid/ready channels for input items, result bytes and register writes.
// ----------------------------------------------------------------------------
interface aftf_item_if;
  import aftf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [0:0]           operation;
  logic [ByteW-1:0]     frame_id;
  logic [Addr64W-1:0]   dest_addr64;
  logic [Addr16W-1:0]   dest_addr16;
  logic [ByteW-1:0]     radius;
  logic [ByteW-1:0]     send_options;
  logic [PlenW-1:0]     payload_length;
  logic [ByteW-1:0]     payload_byte;

  modport source (
    output valid, operation, frame_id, dest_addr64, dest_addr16, radius,
           send_options, payload_length, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, frame_id, dest_addr64, dest_addr16, radius,
           send_options, payload_length, payload_byte,
    output ready
  );
endinterface

interface aftf_result_if;
  import aftf_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             last_in_run;
  logic             frame_done;
  logic             order_error;

  modport source (
    output valid, out_byte, last_in_run, frame_done, order_error,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_in_run, frame_done, order_error,
    output ready
  );
endinterface

interface aftf_cfg_if;
  import aftf_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- rtl/core/api_frame_transmit_framer.sv -----
// Path: a taken item is held in the work stage, and each result byte is registered in the output register.
// Throughput: one result byte per cycle while the output is not stalled,
// limited by the single output register; a payload item yields one byte
// (two when it closes the frame), a header item 17 bytes (18 with empty payload).
// Reset: asynchronous, active low; clears the checksum, closes any frame
// and restores the start and API id registers.
// ----------------------------------------------------------------------------
// Transmit frame framer
// Serializes transmit-request API frames byte by byte with a closing checksum.
// ----------------------------------------------------------------------------
module api_frame_transmit_framer #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input logic          clk_i,
  input logic          rst_ni,
  aftf_item_if.sink    item_i,
  aftf_result_if.source result_o,
  aftf_cfg_if.sink     cfg_i
);
  import aftf_pkg::*;

  localparam logic [31:0] MaxPayloadW = 32'(MAX_PAYLOAD);

  // Configuration registers
  logic [ByteW-1:0] frame_start_q, tx_api_id_q;

  // Work stage: held item and byte position within its results
  logic                stage_valid_q;
  op_e                 op_q;
  logic [ByteW-1:0]    frame_id_q;
  logic [Addr64W-1:0]  addr64_q;
  logic [Addr16W-1:0]  addr16_q;
  logic [ByteW-1:0]    radius_q;
  logic [ByteW-1:0]    options_q;
  logic [PlenW-1:0]    plen_q;
  logic [ByteW-1:0]    pbyte_q;
  logic [IdxW-1:0]     idx_q;

  // Frame state
  logic [ByteW-1:0] sum_q, sum_d;
  logic [PlenW-1:0] rem_q, rem_d;

  // Output register
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q, out_done_q, out_err_q;

  // Emit decode
  logic             emit, item_accept;
  logic [ByteW-1:0] emit_byte;
  logic             emit_last, emit_done, emit_err, emit_summed;
  logic [PlenW-1:0] plen_sat;
  logic [FlenW-1:0] flen;
  logic [ByteW-1:0] hdr_bytes [2**IdxW];

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_start_q <= FrameStartRst;
      tx_api_id_q   <= TxApiIdRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgFrameStart: frame_start_q <= cfg_i.data;
        CfgTxApiId:    tx_api_id_q   <= cfg_i.data;
        default:       ;
      endcase
    end
  end

  // Clamp the payload length to the supported maximum
  always_comb begin
    if (32'(item_i.payload_length) > MaxPayloadW) begin
      plen_sat = MaxPayloadW[PlenW-1:0];
    end else begin
      plen_sat = item_i.payload_length;
    end
  end

  // Produce a byte whenever the output register is free or drains
  assign emit        = stage_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !stage_valid_q || (emit && emit_last);
  assign item_accept = item_i.valid && item_i.ready;

  // Hold the item in the work stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      idx_q         <= '0;
    end else if (item_accept) begin
      stage_valid_q <= 1'b1;
      idx_q         <= '0;
    end else if (emit) begin
      if (emit_last) begin
        stage_valid_q <= 1'b0;
      end
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_accept) begin
      op_q       <= op_e'(item_i.operation);
      frame_id_q <= item_i.frame_id;
      addr64_q   <= item_i.dest_addr64;
      addr16_q   <= item_i.dest_addr16;
      radius_q   <= item_i.radius;
      options_q  <= item_i.send_options;
      plen_q     <= plen_sat;
      pbyte_q    <= item_i.payload_byte;
    end
  end

  // Lay out the header bytes in transmit order
  assign flen = FixedBodyLen + {{(FlenW-PlenW){1'b0}}, plen_q};

  always_comb begin
    for (int i = 0; i < 2**IdxW; i++) begin
      hdr_bytes[i] = '0;
    end
    hdr_bytes[0]  = frame_start_q;
    hdr_bytes[1]  = flen[15:8];
    hdr_bytes[2]  = flen[7:0];
    hdr_bytes[3]  = tx_api_id_q;
    hdr_bytes[4]  = frame_id_q;
    for (int i = 0; i < 8; i++) begin
      hdr_bytes[5+i] = addr64_q[(7-i)*8 +: 8];
    end
    hdr_bytes[13] = addr16_q[15:8];
    hdr_bytes[14] = addr16_q[7:0];
    hdr_bytes[15] = radius_q;
    hdr_bytes[16] = options_q;
  end

  // Select the byte for the current position
  always_comb begin
    emit_byte   = CsumBase - sum_q;
    emit_last   = 1'b1;
    emit_done   = 1'b1;
    emit_err    = 1'b0;
    emit_summed = 1'b0;
    case (op_q)
      OpHeader: begin
        if (idx_q != CsumHdrIdx) begin
          emit_byte   = hdr_bytes[idx_q];
          emit_done   = 1'b0;
          emit_last   = (idx_q == LastHdrIdx) && (plen_q != '0);
          emit_summed = (idx_q >= SumStartIdx);
        end
      end
      OpPayload: begin
        if (idx_q == '0) begin
          emit_done = 1'b0;
          if (rem_q == '0) begin
            emit_byte = '0;
            emit_err  = 1'b1;
          end else begin
            emit_byte   = pbyte_q;
            emit_summed = 1'b1;
            emit_last   = (rem_q != PlenW'(1));
          end
        end
      end
      default: ;
    endcase
  end

  // Advance the checksum and the payload count
  always_comb begin
    sum_d = sum_q;
    rem_d = rem_q;
    if (emit) begin
      if (op_q == OpHeader && idx_q == '0) begin
        sum_d = '0;
        rem_d = plen_q;
      end
      if (emit_summed) begin
        sum_d = sum_q + emit_byte;
        if (op_q == OpPayload) begin
          rem_d = rem_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      rem_q <= '0;
    end else begin
      sum_q <= sum_d;
      rem_q <= rem_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
      out_done_q <= emit_done;
      out_err_q  <= emit_err;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.out_byte    = out_byte_q;
  assign result_o.last_in_run = out_last_q;
  assign result_o.frame_done  = out_done_q;
  assign result_o.order_error = out_err_q;

`ifndef SYNTHESIS
  // The checksum closes a frame only once all payload bytes are in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_done) |-> (rem_q == '0))
    else $error("checksum emitted with payload bytes outstanding");

  // An error result is a lone zero byte that ends its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_err) |-> (emit_last && !emit_done && emit_byte == '0))
    else $error("malformed order error result");

  // A checksum always ends the item's run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_done) |-> emit_last)
    else $error("checksum not marked last in run");

  // Each emitted byte lands in the output register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (out_valid_q && out_byte_q == $past(emit_byte)))
    else $error("emitted byte lost");

  // An empty work stage never blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_valid_q |-> item_i.ready)
    else $error("input stalled with idle work stage");
`endif

endmodule
